>>> design/ll1_table_parse_engine_top_defines.svh
// Assertion macros for the LL(1) table parse engine.
`ifndef LL1_TABLE_PARSE_ENGINE_TOP_DEFINES_SVH
`define LL1_TABLE_PARSE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define LTPE_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ltpe invariant violated");
`define LTPE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ltpe implication violated");
`define LTPE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ltpe next-cycle check violated");
`else
`define LTPE_ASSERT(lbl, expr)
`define LTPE_ASSERT_IMP(lbl, ante, cons)
`define LTPE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/ltpe_pkg.sv
// Shared codes and controller/datapath interface types of the parse engine.
package ltpe_pkg;
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TOKEN = 2'd1;
   localparam logic [1:0] CMD_ENTRY = 2'd2;
   localparam logic [1:0] CMD_RHS   = 2'd3;

   localparam logic [2:0] KIND_EMPTY = 3'd0;
   localparam logic [2:0] KIND_SYNC  = 3'd1;
   localparam logic [2:0] KIND_SKIP  = 3'd2;
   localparam logic [2:0] KIND_EPS   = 3'd3;
   localparam logic [2:0] KIND_PROD  = 3'd4;

   localparam logic [2:0] RES_RULE     = 3'd0;
   localparam logic [2:0] RES_MISMATCH = 3'd1;
   localparam logic [2:0] RES_SYNC     = 3'd2;
   localparam logic [2:0] RES_SKIP     = 3'd3;
   localparam logic [2:0] RES_VERDICT  = 3'd4;

   localparam logic [1:0] VST_OK       = 2'd0;
   localparam logic [1:0] VST_ERR      = 2'd1;
   localparam logic [1:0] VST_OVERFLOW = 2'd2;
   localparam logic [1:0] VST_LIMIT    = 2'd3;

   localparam logic [1:0] CSR_START_SYMBOL = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;

   typedef struct packed {
      logic       ready;
      logic       clr_step;
      logic       start2;
      logic       rd_top;
      logic       rd_entry;
      logic       pop;
      logic       step_inc;
      logic       exp_init;
      logic       rd_rhs;
      logic       push;
      logic       emit;
      logic       flush;
      logic [2:0] res_kind;
      logic [1:0] res_status;
   } ltpe_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic       acc_start;
      logic       acc_token;
      logic       finished;
      logic       level_zero;
      logic       top_term;
      logic       top_match;
      logic       is_end;
      logic       vst_match;
      logic       cnt_zero;
      logic       ovf;
      logic       steps_lim;
      logic       k_one;
      logic       emit_ok;
      logic       pend_valid;
      logic [2:0] ent_kind;
   } ltpe_stat_type;
endpackage

>>> design/ltpe_ctrl.sv
// Parse-step sequencer of the parse engine.
module ltpe_ctrl import ltpe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ltpe_stat_type stat,
   output ltpe_cmd_type  cmd
);
   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b00000000001,
      ST_IDLE    = 11'b00000000010,
      ST_START2  = 11'b00000000100,
      ST_TOP_RD  = 11'b00000001000,
      ST_TOP_USE = 11'b00000010000,
      ST_ENT_USE = 11'b00000100000,
      ST_RHS_RD  = 11'b00001000000,
      ST_RHS_WR  = 11'b00010000000,
      ST_EMIT    = 11'b00100000000,
      ST_FLUSH   = 11'b01000000000,
      ST_SPARE   = 11'b10000000000
   } state_type;

   typedef enum logic [1:0] {
      NXT_LOOP  = 2'd0,
      NXT_FLUSH = 2'd1,
      NXT_VERR  = 2'd2
   } nxt_type;

   state_type  state_ff, state_in;
   nxt_type    nxt_ff, nxt_in;
   logic [2:0] res_kind_ff, res_kind_in;
   logic [1:0] res_status_ff, res_status_in;

   always_comb begin
      cmd           = '0;
      cmd.res_kind  = res_kind_ff;
      cmd.res_status = res_status_ff;
      state_in      = state_ff;
      nxt_in        = nxt_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.acc_start) state_in = ST_START2;
            else if (stat.acc_token && !stat.finished) state_in = ST_TOP_RD;
         end
         ST_START2: begin
            cmd.start2 = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_TOP_RD: begin
            if (stat.level_zero) begin
               res_kind_in   = RES_VERDICT;
               res_status_in = VST_ERR;
               nxt_in        = NXT_FLUSH;
               state_in      = ST_EMIT;
            end else begin
               cmd.rd_top = 1'b1;
               state_in   = ST_TOP_USE;
            end
         end
         ST_TOP_USE: begin
            if (stat.top_term) begin
               if (stat.top_match) begin
                  cmd.pop = 1'b1;
                  if (stat.is_end) begin
                     res_kind_in   = RES_VERDICT;
                     res_status_in = stat.vst_match ? VST_ERR : VST_OK;
                     nxt_in        = NXT_FLUSH;
                     state_in      = ST_EMIT;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  res_kind_in   = RES_MISMATCH;
                  res_status_in = VST_OK;
                  nxt_in        = stat.is_end ? NXT_VERR : NXT_FLUSH;
                  state_in      = ST_EMIT;
               end
            end else begin
               cmd.rd_entry = 1'b1;
               state_in     = ST_ENT_USE;
            end
         end
         ST_ENT_USE: begin
            res_status_in = VST_OK;
            if (stat.ent_kind == KIND_SKIP) begin
               res_kind_in = RES_SKIP;
               nxt_in      = stat.is_end ? NXT_VERR : NXT_FLUSH;
               state_in    = ST_EMIT;
            end else if (stat.steps_lim) begin
               res_kind_in   = RES_VERDICT;
               res_status_in = VST_LIMIT;
               nxt_in        = NXT_FLUSH;
               state_in      = ST_EMIT;
            end else if (stat.ent_kind == KIND_SYNC || stat.ent_kind == KIND_EMPTY) begin
               cmd.step_inc = 1'b1;
               cmd.pop      = 1'b1;
               res_kind_in  = RES_SYNC;
               nxt_in       = NXT_LOOP;
               state_in     = ST_EMIT;
            end else if (stat.ent_kind == KIND_EPS || stat.cnt_zero) begin
               cmd.step_inc = 1'b1;
               cmd.pop      = 1'b1;
               res_kind_in  = RES_RULE;
               nxt_in       = NXT_LOOP;
               state_in     = ST_EMIT;
            end else if (stat.ovf) begin
               cmd.step_inc  = 1'b1;
               res_kind_in   = RES_VERDICT;
               res_status_in = VST_OVERFLOW;
               nxt_in        = NXT_FLUSH;
               state_in      = ST_EMIT;
            end else begin
               cmd.step_inc = 1'b1;
               cmd.pop      = 1'b1;
               cmd.exp_init = 1'b1;
               state_in     = ST_RHS_RD;
            end
         end
         ST_RHS_RD: begin
            cmd.rd_rhs = 1'b1;
            state_in   = ST_RHS_WR;
         end
         ST_RHS_WR: begin
            cmd.push = 1'b1;
            if (stat.k_one) begin
               res_kind_in   = RES_RULE;
               res_status_in = VST_OK;
               nxt_in        = NXT_LOOP;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_RHS_RD;
            end
         end
         ST_EMIT: begin
            if (stat.emit_ok) begin
               cmd.emit = 1'b1;
               case (nxt_ff)
                  NXT_LOOP: state_in = ST_TOP_RD;
                  NXT_VERR: begin
                     res_kind_in   = RES_VERDICT;
                     res_status_in = VST_ERR;
                     nxt_in        = NXT_FLUSH;
                  end
                  default: state_in = ST_FLUSH;
               endcase
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.emit_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         nxt_ff        <= NXT_FLUSH;
         res_kind_ff   <= RES_RULE;
         res_status_ff <= VST_OK;
      end else begin
         state_ff      <= state_in;
         nxt_ff        <= nxt_in;
         res_kind_ff   <= res_kind_in;
         res_status_ff <= res_status_in;
      end
   end
endmodule

>>> design/ltpe_datapath.sv
// Stack, parse tables, configuration and result staging of the parse engine.
`include "ll1_table_parse_engine_top_defines.svh"
module ltpe_datapath import ltpe_pkg::*; #(
   parameter int TERMINAL_COUNT    = 64,
   parameter int NONTERMINAL_COUNT = 64,
   parameter int MAX_RHS           = 8,
   parameter int STACK_DEPTH       = 256,
   parameter int MAX_STEPS         = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   input  logic [5:0]    req_token,
   input  logic [5:0]    req_table_nonterminal,
   input  logic [2:0]    req_entry_kind,
   input  logic [7:0]    req_rule_number,
   input  logic [3:0]    req_rhs_count,
   input  logic [2:0]    req_rhs_position,
   input  logic [6:0]    req_rhs_symbol,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [6:0]    csr_data,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [2:0]    rsp_result_kind,
   output logic [7:0]    rsp_applied_rule,
   output logic [6:0]    rsp_expected_symbol,
   output logic [5:0]    rsp_found_token,
   output logic [1:0]    rsp_verdict_status,
   output logic          rsp_final_item,
   input  ltpe_cmd_type  cmd,
   output ltpe_stat_type stat
);
   localparam int TABLE = TERMINAL_COUNT * NONTERMINAL_COUNT;
   localparam int TW    = $clog2(TABLE);
   localparam int RW    = $clog2(TABLE * MAX_RHS);
   localparam int CW    = $clog2(MAX_RHS + 1);
   localparam int SW    = $clog2(STACK_DEPTH);
   localparam int LW    = $clog2(STACK_DEPTH + 1);
   localparam int SCW   = $clog2(MAX_STEPS + 1);
   localparam int EW    = 3 + 8 + CW;

   logic [EW-1:0] ent_mem [TABLE];
   logic [6:0]    rhs_mem [TABLE * MAX_RHS];
   logic [6:0]    stk_mem [STACK_DEPTH];

   logic [6:0]    start_sym_ff;
   logic [5:0]    end_ff;
   logic [TW-1:0] clr_ff;
   logic [LW-1:0] level_ff;
   logic [LW-1:0] level_m1;
   logic          err_ff, finished_ff;
   logic [SCW-1:0] steps_ff;
   logic [CW-1:0] k_ff;
   logic [5:0]    tok_ff;
   logic [6:0]    stk_rd_ff;
   logic [EW-1:0] ent_rd_ff;
   logic          rng_ff;
   logic [TW-1:0] idx_ff;
   logic [6:0]    rhs_rd_ff;

   logic          accept, in_table;
   logic [TW-1:0] req_idx, top_idx;
   logic          top_rng;
   logic [2:0]    kind_norm;
   logic [CW-1:0] cnt_sat;
   logic [2:0]    ent_kind_raw;
   logic [7:0]    ent_rule;
   logic [CW-1:0] ent_cnt;
   logic          out_free;

   logic          pend_valid_ff, rsp_valid_ff;
   logic [2:0]    pkind_ff, rkind_ff;
   logic [7:0]    prule_ff, rrule_ff;
   logic [6:0]    psym_ff, rsym_ff;
   logic [5:0]    ptok_ff, rtok_ff;
   logic [1:0]    pst_ff, rst_ff;
   logic          rfinal_ff;

   assign accept    = req_valid && cmd.ready;
   assign in_table  = (int'(req_table_nonterminal) < NONTERMINAL_COUNT) &&
                      (int'(req_token) < TERMINAL_COUNT);
   assign req_idx   = TW'(int'(req_table_nonterminal) * TERMINAL_COUNT + int'(req_token));
   assign top_idx   = TW'(int'(stk_rd_ff[5:0]) * TERMINAL_COUNT + int'(tok_ff));
   assign top_rng   = (int'(stk_rd_ff[5:0]) < NONTERMINAL_COUNT) &&
                      (int'(tok_ff) < TERMINAL_COUNT);
   assign kind_norm = (req_entry_kind > KIND_PROD) ? KIND_EMPTY : req_entry_kind;
   assign cnt_sat   = (int'(req_rhs_count) > MAX_RHS) ? CW'(MAX_RHS) : CW'(req_rhs_count);
   assign ent_kind_raw = ent_rd_ff[EW-1 -: 3];
   assign ent_rule  = ent_rd_ff[CW +: 8];
   assign ent_cnt   = ent_rd_ff[CW-1:0];
   assign level_m1  = level_ff - LW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat            = '0;
      stat.clear_last = (clr_ff == TW'(TABLE - 1));
      stat.acc_start  = accept && (req_command == CMD_START);
      stat.acc_token  = accept && (req_command == CMD_TOKEN);
      stat.finished   = finished_ff;
      stat.level_zero = (level_ff == '0);
      stat.top_term   = !stk_rd_ff[6];
      stat.top_match  = (stk_rd_ff[5:0] == tok_ff);
      stat.is_end     = (tok_ff == end_ff);
      stat.vst_match  = err_ff || (level_ff != LW'(1));
      stat.cnt_zero   = (ent_cnt == '0);
      stat.ovf        = (int'(level_ff) - 1 + int'(ent_cnt)) > STACK_DEPTH;
      stat.steps_lim  = (steps_ff == SCW'(MAX_STEPS));
      stat.k_one      = (k_ff == CW'(1));
      stat.emit_ok    = !pend_valid_ff || out_free;
      stat.pend_valid = pend_valid_ff;
      stat.ent_kind   = rng_ff ? ent_kind_raw : KIND_EMPTY;
   end

   // Parse table, rhs table and stack memories.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         ent_mem[clr_ff] <= '0;
      end else if (accept && req_command == CMD_ENTRY && in_table) begin
         ent_mem[req_idx] <= {kind_norm, req_rule_number, cnt_sat};
      end
      if (cmd.rd_entry) begin
         ent_rd_ff <= ent_mem[top_idx];
         idx_ff    <= top_idx;
         rng_ff    <= top_rng;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_RHS && in_table &&
          int'(req_rhs_position) < MAX_RHS) begin
         rhs_mem[RW'(int'(req_idx) * MAX_RHS + int'(req_rhs_position))] <= req_rhs_symbol;
      end
      if (cmd.rd_rhs) begin
         rhs_rd_ff <= rhs_mem[RW'(int'(idx_ff) * MAX_RHS + int'(k_ff) - 1)];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_START) begin
         stk_mem[SW'(0)] <= {1'b0, end_ff};
      end else if (cmd.start2) begin
         stk_mem[SW'(1)] <= start_sym_ff;
      end else if (cmd.push) begin
         stk_mem[level_ff[SW-1:0]] <= rhs_rd_ff;
      end
      if (cmd.rd_top) begin
         stk_rd_ff <= stk_mem[level_m1[SW-1:0]];
      end
      if (accept) tok_ff <= req_token;
      if (cmd.exp_init) k_ff <= ent_cnt;
      else if (cmd.push) k_ff <= k_ff - CW'(1);
   end

   // Control state of the parse.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_sym_ff <= 7'd64;
         end_ff       <= 6'd0;
         clr_ff       <= '0;
         level_ff     <= '0;
         err_ff       <= 1'b0;
         finished_ff  <= 1'b1;
         steps_ff     <= '0;
      end else begin
         if (csr_valid && csr_index == CSR_START_SYMBOL) start_sym_ff <= csr_data;
         if (csr_valid && csr_index == CSR_END_MARKER) end_ff <= csr_data[5:0];
         if (cmd.clr_step) clr_ff <= clr_ff + TW'(1);
         if (accept && req_command == CMD_START) begin
            level_ff    <= LW'(2);
            err_ff      <= 1'b0;
            finished_ff <= 1'b0;
         end else if (cmd.pop) begin
            level_ff <= level_m1;
         end else if (cmd.push) begin
            level_ff <= level_ff + LW'(1);
         end
         if (accept && req_command == CMD_TOKEN) steps_ff <= '0;
         else if (cmd.step_inc) steps_ff <= steps_ff + SCW'(1);
         if (cmd.emit) begin
            if (cmd.res_kind == RES_VERDICT) finished_ff <= 1'b1;
            if (cmd.res_kind == RES_MISMATCH || cmd.res_kind == RES_SKIP ||
                cmd.res_kind == RES_SYNC) err_ff <= 1'b1;
         end
      end
   end

   // Result staging: one pending slot ahead of the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
         rkind_ff  <= pkind_ff;
         rrule_ff  <= prule_ff;
         rsym_ff   <= psym_ff;
         rtok_ff   <= ptok_ff;
         rst_ff    <= pst_ff;
         rfinal_ff <= cmd.flush;
      end
      if (cmd.emit) begin
         pkind_ff <= cmd.res_kind;
         prule_ff <= (cmd.res_kind == RES_RULE) ? ent_rule : 8'd0;
         psym_ff  <= (cmd.res_kind == RES_VERDICT) ? 7'd0 : stk_rd_ff;
         ptok_ff  <= tok_ff;
         pst_ff   <= (cmd.res_kind == RES_VERDICT) ? cmd.res_status : VST_OK;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rkind_ff;
   assign rsp_applied_rule    = rrule_ff;
   assign rsp_expected_symbol = rsym_ff;
   assign rsp_found_token     = rtok_ff;
   assign rsp_verdict_status  = rst_ff;
   assign rsp_final_item      = rfinal_ff;

   `LTPE_ASSERT(a_level_bound, int'(level_ff) <= STACK_DEPTH)
   `LTPE_ASSERT_IMP(a_push_room, cmd.push, int'(level_ff) < STACK_DEPTH)
   `LTPE_ASSERT_IMP(a_emit_room, cmd.emit && pend_valid_ff, out_free)
   `LTPE_ASSERT_NXT(a_verdict_ends, cmd.emit && cmd.res_kind == RES_VERDICT, finished_ff)
endmodule

>>> design/ll1_table_parse_engine_top.sv
// Table writes are taken in the idle state; start then passes ST_START2 for the start symbol.
// A token passes ST_TOP_RD, ST_TOP_USE (stack top), ST_ENT_USE (table entry), ST_RHS_RD and
// ST_RHS_WR per pushed symbol, ST_EMIT per result (waits on rsp_stall), ST_FLUSH for the last.
// One transaction is in flight at a time; results pass a pending slot and an output register.
// Reset is synchronous; after it a clearing pass over all TERMINAL_COUNT*NONTERMINAL_COUNT
// table entries (4096 by default) empties the parse table while req_stall stays high.
module ll1_table_parse_engine_top import ltpe_pkg::*; #(
   parameter int TERMINAL_COUNT    = 64,
   parameter int NONTERMINAL_COUNT = 64,
   parameter int MAX_RHS           = 8,
   parameter int STACK_DEPTH       = 256,
   parameter int MAX_STEPS         = 32
) (
   input  logic       clock,
   input  logic       reset,
   // input transactions
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [5:0] req_token,
   input  logic [5:0] req_table_nonterminal,
   input  logic [2:0] req_entry_kind,
   input  logic [7:0] req_rule_number,
   input  logic [3:0] req_rhs_count,
   input  logic [2:0] req_rhs_position,
   input  logic [6:0] req_rhs_symbol,
   // configuration writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data,
   // result transactions
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_applied_rule,
   output logic [6:0] rsp_expected_symbol,
   output logic [5:0] rsp_found_token,
   output logic [1:0] rsp_verdict_status,
   output logic       rsp_final_item
);
   ltpe_cmd_type  cmd;
   ltpe_stat_type stat;

   // Take a request only while the sequencer sits idle.
   assign req_stall = !cmd.ready;
   // Configuration registers accept a write in any cycle outside reset.
   assign csr_ready = 1'b1;

   ltpe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ltpe_datapath #(
      .TERMINAL_COUNT    (TERMINAL_COUNT),
      .NONTERMINAL_COUNT (NONTERMINAL_COUNT),
      .MAX_RHS           (MAX_RHS),
      .STACK_DEPTH       (STACK_DEPTH),
      .MAX_STEPS         (MAX_STEPS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_command           (req_command),
      .req_token             (req_token),
      .req_table_nonterminal (req_table_nonterminal),
      .req_entry_kind        (req_entry_kind),
      .req_rule_number       (req_rule_number),
      .req_rhs_count         (req_rhs_count),
      .req_rhs_position      (req_rhs_position),
      .req_rhs_symbol        (req_rhs_symbol),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_applied_rule      (rsp_applied_rule),
      .rsp_expected_symbol   (rsp_expected_symbol),
      .rsp_found_token       (rsp_found_token),
      .rsp_verdict_status    (rsp_verdict_status),
      .rsp_final_item        (rsp_final_item),
      .cmd                   (cmd),
      .stat                  (stat)
   );
endmodule
